### rtl/btb2_pkg.sv
`default_nettype none
package btb2_pkg;

    typedef logic [1:0] t_cmd;

    // Command codes. The fourth code has no meaning of its own and acts as a lookup.
    localparam t_cmd CMD_LOOKUP = 2'd0;
    localparam t_cmd CMD_INSERT = 2'd1;
    localparam t_cmd CMD_UPDATE = 2'd2;

    typedef logic [1:0] t_ctr;

    localparam t_ctr CTR_MIN  = 2'd0;
    localparam t_ctr CTR_MAX  = 2'd3;
    localparam t_ctr CTR_WEAK = 2'd2;

    // Result of the associative search, before this transaction changes anything.
    typedef struct packed {
        logic        hit;
        logic [31:0] target;
        t_ctr        counter;
    } t_lookup;

    // Table write request produced by the control logic.
    typedef struct packed {
        logic        en;
        logic        insert;
        logic [31:0] target;
        t_ctr        counter;
    } t_write;

endpackage
`default_nettype wire

### rtl/branch_target_buffer_2bit_core.sv
`default_nettype none
// Fully associative branch target buffer with two-bit saturating counters.
// Every transaction carries a command (lookup, insert, update), a branch PC,
// an offset and a resolved outcome, and returns exactly one result
// transaction. The block takes one transaction per cycle when the result side
// keeps up. A transaction sits in the input register while the tag compare
// against all ENTRIES slots runs, and when it moves on, the table write and
// the load of the result register happen at the same edge. Since the table is
// written at the same edge that finishes a transaction, the next one always
// sees the updated contents and no forwarding is involved. The result register
// parts the two sides, so a new input transaction can still be taken into an
// empty input register while a finished result waits. Entry valid bits clear
// at reset; no clearing pass is needed. An insert on a miss replaces slots in
// round-robin order.
module branch_target_buffer_2bit_core
    import btb2_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // Input channel.
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_command,
    input  wire logic [31:0]        i_branch_pc,
    input  wire logic signed [31:0] i_offset,
    input  wire logic               i_actual_taken,
    // Result channel.
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_hit,
    output logic [31:0]             o_target_addr,
    output logic [1:0]              o_counter_value,
    output logic                    o_predict_taken,
    output logic                    o_mispredict
);

    // Input register.
    logic               r_in_valid;
    t_cmd               r_cmd;
    logic [31:0]        r_pc;
    logic signed [31:0] r_off;
    logic               r_taken;

    // Result register.
    logic               r_out_valid;
    logic               r_hit;
    logic [31:0]        r_target;
    t_ctr               r_ctr;
    logic               r_pred;
    logic               r_miss;

    logic               advance;
    t_lookup            lk;
    t_write             wr;
    logic [31:0]        n_target;
    t_ctr               n_ctr;
    logic               n_pred;
    logic               n_miss;

    // The held transaction moves on whenever the result slot is empty or is
    // being emptied in this cycle.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    btb2_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pc     (r_pc),
        .i_wr     (wr),
        .o_lookup (lk)
    );

    // A miss reads as counter zero, so the prediction is not taken.
    always_comb begin
        n_pred   = lk.hit && (lk.counter >= CTR_WEAK);
        n_target = lk.target;
        n_ctr    = lk.counter;
        n_miss   = 1'b0;
        wr       = '0;
        unique case (r_cmd)
            CMD_INSERT: begin
                n_target  = r_pc + $unsigned(r_off);
                n_ctr     = CTR_MIN;
                wr.en     = advance;
                wr.insert = 1'b1;
                wr.target = n_target;
                wr.counter = CTR_MIN;
            end
            CMD_UPDATE: begin
                n_miss = (n_pred != r_taken);
                if (lk.hit) begin
                    if (r_taken) begin
                        n_ctr = (lk.counter == CTR_MAX) ? CTR_MAX : lk.counter + 2'd1;
                    end else begin
                        n_ctr = (lk.counter == CTR_MIN) ? CTR_MIN : lk.counter - 2'd1;
                    end
                end
                wr.en      = advance && lk.hit;
                wr.counter = n_ctr;
            end
            default: begin
                // Lookup, and the unused code handled the same way.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd   <= i_command;
            r_pc    <= i_branch_pc;
            r_off   <= i_offset;
            r_taken <= i_actual_taken;
        end
        if (advance) begin
            r_hit    <= lk.hit;
            r_target <= n_target;
            r_ctr    <= n_ctr;
            r_pred   <= n_pred;
            r_miss   <= n_miss;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_hit;
    assign o_target_addr   = r_target;
    assign o_counter_value = r_ctr;
    assign o_predict_taken = r_pred;
    assign o_mispredict    = r_miss;

`ifndef SYNTH
    a_advance_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_valid)
        else $error("finished transaction did not reach the result register");
    a_miss_counter_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_counter_value == CTR_MIN && !o_predict_taken))
        else $error("miss reported a nonzero counter or a taken prediction");
    a_insert_clears_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_cmd == CMD_INSERT) |=> (o_counter_value == CTR_MIN && !o_mispredict))
        else $error("insert result carries a counter or a misprediction");
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_pc) && $stable(r_cmd)))
        else $error("held transaction changed while stalled");
`endif

endmodule
`default_nettype wire

### rtl/btb2_table.sv
`default_nettype none
module btb2_table
    import btb2_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_pc,
    input  wire t_write      i_wr,
    output t_lookup          o_lookup
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [ENTRIES-1:0] r_valid;
    logic [31:0]        r_tag    [ENTRIES];
    logic [31:0]        r_target [ENTRIES];
    t_ctr               r_ctr    [ENTRIES];
    logic [IDX_W-1:0]   r_victim;
    logic [IDX_W-1:0]   n_victim;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] wsel;
    t_lookup            lk;

    // Parallel tag compare; tags are unique, so the matches are at most one-hot
    // and the read is an AND-OR over the entries.
    always_comb begin
        lk = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            match[i]   = r_valid[i] && (r_tag[i] == i_pc);
            lk.hit     = lk.hit | match[i];
            lk.target  = lk.target | (r_target[i] & {32{match[i]}});
            lk.counter = lk.counter | (r_ctr[i] & {2{match[i]}});
        end
    end

    assign o_lookup = lk;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            wsel[i] = lk.hit ? match[i] : (r_victim == IDX_W'(i));
        end
        n_victim = r_victim;
        if (i_wr.en && i_wr.insert && !lk.hit) begin
            n_victim = (r_victim == IDX_W'(ENTRIES - 1)) ? '0 : r_victim + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_victim <= '0;
        end else begin
            r_victim <= n_victim;
            for (int i = 0; i < ENTRIES; i++) begin
                if (i_wr.en && i_wr.insert && wsel[i]) begin
                    r_valid[i] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_wr.en && wsel[i]) begin
                r_ctr[i] <= i_wr.counter;
                if (i_wr.insert) begin
                    r_tag[i]    <= i_pc;
                    r_target[i] <= i_wr.target;
                end
            end
        end
    end

`ifndef SYNTH
    a_victim_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.en && i_wr.insert) |=> (r_valid != '0))
        else $error("insert left no valid entry");
    a_update_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.en && !i_wr.insert) |-> lk.hit)
        else $error("counter write without a matching entry");
    a_victim_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr.en && i_wr.insert && !lk.hit) |=> (r_victim == $past(r_victim)))
        else $error("victim pointer moved without an insert miss");
`endif

endmodule
`default_nettype wire

### tb/branch_target_buffer_2bit_core_tb.sv
`timescale 1ns / 100ps

// Testbench for the two-bit branch target buffer.
module branch_target_buffer_2bit_core_tb;
    import btb2_pkg::*;

    // Geometry of the buffer under test.
    localparam int ENTRIES = 16;

    // The fourth command code has no name in the package; the block treats it as a lookup.
    localparam t_cmd CMD_RESERVED = 2'd3;

    // Size of the random part and of the recurring branch address pool.
    localparam int RANDOM_ITEMS = 950;
    localparam int PC_POOL_SIZE = 24;

    // Once this many transactions have been accepted, the result side holds
    // off for a long stretch so that the block fills up and stalls its input.
    localparam int PRESSURE_AT  = 300;
    localparam int PRESSURE_LEN = 250;

    // Cycles in which neither channel moves a transaction before the run is given up.
    localparam int WATCHDOG_LIMIT = 2000;

    // Cycles allowed after the last result for anything stray to show up.
    localparam int DRAIN_CYCLES = 20;

    // The final stretch of the run has no idling on either side.
    localparam int QUIET_TAIL = 100;

    typedef struct packed {
        t_cmd               cmd;
        logic [31:0]        pc;
        logic signed [31:0] offset;
        logic               taken;
    } t_branch_op;

    typedef struct packed {
        logic        hit;
        logic [31:0] target;
        t_ctr        counter;
        logic        predict;
        logic        mispredict;
    } t_btb_resp;

    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_valid        = 1'b0;
    logic [1:0]         i_command      = CMD_LOOKUP;
    logic [31:0]        i_branch_pc    = '0;
    logic signed [31:0] i_offset       = '0;
    logic               i_actual_taken = 1'b0;
    logic               i_ready        = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic               o_hit;
    logic [31:0]        o_target_addr;
    logic [1:0]         o_counter_value;
    logic               o_predict_taken;
    logic               o_mispredict;

    branch_target_buffer_2bit_core #(
        .ENTRIES(ENTRIES)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_branch_pc    (i_branch_pc),
        .i_offset       (i_offset),
        .i_actual_taken (i_actual_taken),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_hit          (o_hit),
        .o_target_addr  (o_target_addr),
        .o_counter_value(o_counter_value),
        .o_predict_taken(o_predict_taken),
        .o_mispredict   (o_mispredict)
    );

    always #6 i_clk = ~i_clk;

    // Branch operations waiting to be offered, and results the shadow table
    // says must come back, oldest first.
    t_branch_op branch_op_q[$];
    t_btb_resp  predicted_resp_q[$];

    // Shadow copy of the buffer contents.
    logic        shadow_valid  [ENTRIES];
    logic [31:0] shadow_tag    [ENTRIES];
    logic [31:0] shadow_target [ENTRIES];
    t_ctr        shadow_counter[ENTRIES];
    logic [3:0]  shadow_victim;

    logic [31:0] pc_pool[PC_POOL_SIZE];

    int  total_ops;
    int  ops_accepted   = 0;
    int  mismatch_count = 0;
    int  quiet_cycles   = 0;
    logic op_just_taken = 1'b0;

    // Idling is allowed except in every third stretch of 120 transactions and
    // in the last part of the run.
    function automatic bit idling_allowed();
        return (ops_accepted < total_ops - QUIET_TAIL) && (((ops_accepted / 120) % 3) != 2);
    endfunction

    // Applies one operation to the shadow table and returns the result that
    // the block must produce for it. All matching and counter judgments are
    // made on the contents as they stood before this operation.
    function automatic t_btb_resp btb_predict(t_branch_op op);
        t_btb_resp resp;
        int        slot;
        int        way;
        t_ctr      old_ctr;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (slot < 0 && shadow_valid[i] && shadow_tag[i] == op.pc) begin
                slot = i;
            end
        end
        resp.hit        = (slot >= 0);
        old_ctr         = resp.hit ? shadow_counter[slot] : CTR_MIN;
        resp.predict    = (old_ctr >= CTR_WEAK);
        resp.target     = resp.hit ? shadow_target[slot] : 32'd0;
        resp.counter    = old_ctr;
        resp.mispredict = 1'b0;
        case (op.cmd)
            CMD_INSERT: begin
                // A hit is overwritten in place; a miss takes the round-robin victim.
                way = resp.hit ? slot : int'(shadow_victim);
                if (!resp.hit) begin
                    shadow_victim = (shadow_victim == ENTRIES - 1) ? 4'd0 : shadow_victim + 4'd1;
                end
                resp.target          = op.pc + op.offset;
                resp.counter         = CTR_MIN;
                shadow_valid[way]    = 1'b1;
                shadow_tag[way]      = op.pc;
                shadow_target[way]   = resp.target;
                shadow_counter[way]  = CTR_MIN;
            end
            CMD_UPDATE: begin
                // A miss is judged as a counter of zero and leaves the table alone.
                resp.mispredict = (resp.predict != op.taken);
                if (resp.hit) begin
                    if (op.taken && resp.counter != CTR_MAX) begin
                        resp.counter = resp.counter + 2'd1;
                    end else if (!op.taken && resp.counter != CTR_MIN) begin
                        resp.counter = resp.counter - 2'd1;
                    end
                    shadow_counter[slot] = resp.counter;
                end
            end
            default: begin
                // Lookups and the reserved code only report what is stored.
            end
        endcase
        return resp;
    endfunction

    task automatic push_op(t_cmd cmd, logic [31:0] pc, logic [31:0] offset, logic taken);
        t_branch_op op;
        op.cmd    = cmd;
        op.pc     = pc;
        op.offset = offset;
        op.taken  = taken;
        branch_op_q.insert(branch_op_q.size(), op);
    endtask

    function automatic logic [31:0] pick_pc();
        int idx;
        idx = $urandom_range(0, PC_POOL_SIZE - 1);
        // Now and then a pool address is retired so that fresh tags keep arriving.
        if ($urandom_range(0, 19) == 0) begin
            pc_pool[idx] = $urandom;
        end
        if ($urandom_range(0, 9) == 0) begin
            return $urandom;
        end
        return pc_pool[idx];
    endfunction

    function automatic logic [31:0] pick_offset();
        case ($urandom_range(0, 39))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Weighted choice among the follow-up operations on a known branch.
    function automatic t_cmd pick_followup_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return CMD_UPDATE;
        end else if (r < 90) begin
            return CMD_LOOKUP;
        end else if (r < 95) begin
            return CMD_RESERVED;
        end
        return CMD_INSERT;
    endfunction

    // Stimulus, reset and the end of the run.
    initial begin
        int burst_len;
        logic [31:0] pc;
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_valid[i]   = 1'b0;
            shadow_tag[i]     = '0;
            shadow_target[i]  = '0;
            shadow_counter[i] = CTR_MIN;
        end
        shadow_victim = '0;
        for (int i = 0; i < PC_POOL_SIZE; i++) begin
            pc_pool[i] = $urandom;
        end

        // Misses on an empty table: a lookup, then updates whose misprediction
        // flag must follow the outcome.
        push_op(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b0);
        push_op(CMD_UPDATE, 32'h0000_0000, 32'h0000_0000, 1'b1);
        push_op(CMD_UPDATE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        // Insert with a negative offset, then a hit on it.
        push_op(CMD_INSERT, 32'h0000_1000, 32'hFFFF_FFFC, 1'b0);
        push_op(CMD_LOOKUP, 32'h0000_1000, 32'h0000_0000, 1'b0);
        // Four taken outcomes drive the counter into saturation at the top.
        repeat (4) push_op(CMD_UPDATE, 32'h0000_1000, 32'h0000_0000, 1'b1);
        // Re-insert over a live entry: the counter is cleared and reported as zero.
        push_op(CMD_INSERT, 32'h0000_1000, 32'h0000_0008, 1'b1);
        repeat (2) push_op(CMD_UPDATE, 32'h0000_1000, 32'h0000_0000, 1'b1);
        // Not taken from a strong-ish state mispredicts, then saturates at zero.
        repeat (3) push_op(CMD_UPDATE, 32'h0000_1000, 32'h0000_0000, 1'b0);
        // Targets that wrap around the address space.
        push_op(CMD_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        push_op(CMD_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b1);
        push_op(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 1'b0);
        // The reserved command code behaves as a lookup.
        push_op(CMD_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_op(CMD_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1'b0);
        push_op(CMD_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_op(CMD_LOOKUP, 32'h1234_5678, 32'h5555_5555, 1'b1);

        // Random part. Most of it is an insert followed by a run of updates
        // and lookups on the same branch; the rest are loose operations. The
        // address pool is larger than the table, so entries get evicted.
        total_ops = branch_op_q.size() + RANDOM_ITEMS;
        while (branch_op_q.size() < total_ops) begin
            pc = pick_pc();
            if ($urandom_range(0, 99) < 60) begin
                push_op(CMD_INSERT, pc, pick_offset(), 1'($urandom_range(0, 1)));
                burst_len = $urandom_range(2, 8);
                repeat (burst_len) begin
                    push_op(pick_followup_cmd(), pc, pick_offset(), 1'($urandom_range(0, 1)));
                end
            end else begin
                push_op(t_cmd'($urandom_range(0, 3)), pc, pick_offset(),
                        1'($urandom_range(0, 1)));
            end
        end
        total_ops = branch_op_q.size();

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (ops_accepted < total_ops || predicted_resp_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (predicted_resp_q.size() != 0) begin
            $error("%0d expected results never arrived", predicted_resp_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("branch_target_buffer_2bit_core_tb passed");
        end else begin
            $display("branch_target_buffer_2bit_core_tb failed");
        end
        $finish;
    end

    // Driver: offers the next pending operation at the falling edge and keeps
    // it steady until the block takes it. Gaps come in random bursts.
    int tx_gap_left = 0;
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_valid && !op_just_taken)) begin
            if (tx_gap_left > 0) begin
                tx_gap_left--;
                i_valid <= 1'b0;
            end else if (branch_op_q.size() == 0) begin
                i_valid <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 9) == 0) begin
                tx_gap_left = $urandom_range(1, 19) - 1;
                i_valid <= 1'b0;
            end else begin
                i_command      <= branch_op_q[0].cmd;
                i_branch_pc    <= branch_op_q[0].pc;
                i_offset       <= branch_op_q[0].offset;
                i_actual_taken <= branch_op_q[0].taken;
                i_valid        <= 1'b1;
                void'(branch_op_q.pop_front());
            end
        end
    end

    // Result side readiness: random stall bursts plus one long hold-off.
    int  rx_hold_left = 0;
    bit  pressure_done = 1'b0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_ready <= 1'b0;
            end else if (!pressure_done && ops_accepted >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                rx_hold_left  = PRESSURE_LEN - 1;
                i_ready <= 1'b0;
            end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
                rx_hold_left = $urandom_range(1, 19) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Monitor and scoreboard. A result can never belong to an operation taken
    // at the same edge, so results are checked before the new one is predicted.
    always @(posedge i_clk) begin
        t_btb_resp want;
        op_just_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (predicted_resp_q.size() == 0) begin
                $error("result transaction with no expectation waiting");
                mismatch_count++;
            end else begin
                want = predicted_resp_q.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0b, got %0b", want.hit, o_hit);
                    mismatch_count++;
                end
                if (o_target_addr !== want.target) begin
                    $error("target_addr: expected %08h, got %08h", want.target, o_target_addr);
                    mismatch_count++;
                end
                if (o_counter_value !== want.counter) begin
                    $error("counter_value: expected %0d, got %0d",
                           want.counter, o_counter_value);
                    mismatch_count++;
                end
                if (o_predict_taken !== want.predict) begin
                    $error("predict_taken: expected %0b, got %0b",
                           want.predict, o_predict_taken);
                    mismatch_count++;
                end
                if (o_mispredict !== want.mispredict) begin
                    $error("mispredict: expected %0b, got %0b", want.mispredict, o_mispredict);
                    mismatch_count++;
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            predicted_resp_q.insert(predicted_resp_q.size(),
                                    btb_predict('{i_command, i_branch_pc, i_offset,
                                                  i_actual_taken}));
            ops_accepted++;
        end
    end

    // Watchdog: counts edges at which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("branch_target_buffer_2bit_core_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

### sim.f
rtl/btb2_pkg.sv
rtl/btb2_table.sv
rtl/branch_target_buffer_2bit_core.sv
tb/branch_target_buffer_2bit_core_tb.sv
